FILE: hdl/ipre_pkg.sv
// ----------------------------------------------------------------------------
// ipre_pkg: shared types and constants of the ingress peak rate estimator
// Holds field widths, the queue entry type and the function codes.
// ----------------------------------------------------------------------------
package ipre_pkg;

  localparam int TIME_W    = 62;
  localparam int LEN_W     = 16;
  localparam int RATE_W    = 40;
  localparam int PEAK_W    = 48;
  localparam int DELTA_W   = 49;
  localparam int HOLD_W    = 32;
  localparam int BYTE_COUNT_BITS_DEF = 32;
  localparam logic [31:0] HOLDOFF_RST = 32'd250000000;
  localparam logic [33:0] BPS_SCALE   = 34'd8000000000;

  localparam logic FUNC_ENQ   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] now;
    logic [LEN_W-1:0]  len;
    logic [RATE_W-1:0] cur;
  } ipre_item_t;

endpackage

FILE: hdl/ingress_peak_rate_estimator.sv
// ----------------------------------------------------------------------------
// ingress_peak_rate_estimator: ingress peak bandwidth estimator
// Averages packet spacing and window rates, answers shaper rate queries.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// in_      slave      tdata: now_ns, len_bytes, current_rate_bps; tuser: func
// out_     master     tdata: rate_delta_bps, peak_bps, avg_interval_ns
// cfg_     slave      holdoff_ns, one register
//
// A query is answered in state S_OUT and held there while the output stalls.
// An enqueue closing a window runs S_AVG, S_MUL, S_DIV (the one bit per cycle
// divider) and S_PEAK. Reset is synchronous, active low, and clears control
// state and averages. A two-beat queue lets beats in while the back end works.
module ingress_peak_rate_estimator #(
  parameter int BYTE_COUNT_BITS = ipre_pkg::BYTE_COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // now_ns, len_bytes, current_rate_bps
  input  logic         in_tuser,   // func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // rate_delta_bps, peak_bps, avg_interval_ns
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);
  import ipre_pkg::*;

  logic [HOLD_W-1:0] holdoff_r;
  logic q_valid, q_take;
  ipre_item_t q_item;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) holdoff_r <= HOLDOFF_RST;
    else if (cfg_valid) holdoff_r <= cfg_data;
  end

  ipre_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
  );

  ipre_back #(.BYTE_COUNT_BITS(BYTE_COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
    .q_item(q_item), .holdoff(holdoff_r),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );
endmodule

FILE: hdl/ipre_front.sv
// ----------------------------------------------------------------------------
// ipre_front: input beat capture and two-entry queue
// Unpacks stream beats into items and buffers them for the back end.
// ----------------------------------------------------------------------------
module ipre_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [119:0]         in_tdata,
  input  logic                 in_tuser,
  output logic                 q_valid,
  input  logic                 q_take,
  output ipre_pkg::ipre_item_t q_item
);
  import ipre_pkg::*;

  ipre_item_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_take;
  assign q_item    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].func <= in_tuser;
      mem_r[wp_r].now  <= in_tdata[TIME_W-1:0];
      mem_r[wp_r].len  <= in_tdata[TIME_W+LEN_W-1:TIME_W];
      mem_r[wp_r].cur  <= in_tdata[TIME_W+LEN_W+RATE_W-1:TIME_W+LEN_W];
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("pop from empty queue");
`endif
endmodule

FILE: hdl/ipre_div.sv
// ----------------------------------------------------------------------------
// ipre_div: restoring divider, one quotient bit per cycle
// Divides a 128-bit dividend by a 62-bit divisor, saturating to 48 bits.
// ----------------------------------------------------------------------------
module ipre_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [127:0]                  dividend,
  input  logic [ipre_pkg::TIME_W-1:0]   divisor,
  output logic                          done,
  output logic [ipre_pkg::PEAK_W-1:0]   quot
);
  import ipre_pkg::*;

  logic         busy_r, busy_nxt;
  logic [6:0]   idx_r, idx_nxt;
  logic [127:0] num_r, num_nxt;
  logic [TIME_W:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] d_r;
  logic [PEAK_W-1:0] q_r, q_nxt;
  logic         big_r, big_nxt;
  logic         done_r, done_nxt;
  logic [TIME_W:0] sh;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    big_nxt  = big_r;
    done_nxt = 1'b0;
    sh       = {rem_r[TIME_W-1:0], num_r[127]};
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = 7'd127;
      num_nxt  = dividend;
      rem_nxt  = '0;
      q_nxt    = '0;
      big_nxt  = 1'b0;
    end else if (busy_r) begin
      num_nxt = {num_r[126:0], 1'b0};
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = sh - {1'b0, d_r};
        if (idx_r >= 7'(PEAK_W)) big_nxt = 1'b1;
        else q_nxt[idx_r[5:0]] = 1'b1;
      end else begin
        rem_nxt = sh;
      end
      if (idx_r == 7'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      idx_nxt = idx_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    big_r <= big_nxt;
    if (start) d_r <= divisor;
  end

  assign done = done_r;
  assign quot = big_r ? {PEAK_W{1'b1}} : q_r;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_rem_lt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !$past(start) |-> rem_r < {1'b0, d_r}) else $error("remainder too large");
`endif
endmodule

FILE: hdl/ipre_back.sv
// ----------------------------------------------------------------------------
// ipre_back: estimator state and execution sequencer
// Updates the averages for enqueue items and answers queries.
// ----------------------------------------------------------------------------
module ipre_back #(
  parameter int BYTE_COUNT_BITS = ipre_pkg::BYTE_COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_take,
  input  ipre_pkg::ipre_item_t         q_item,
  input  logic [ipre_pkg::HOLD_W-1:0]  holdoff,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [159:0]                 out_tdata
);
  import ipre_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_AVG = 3'd1, S_MUL = 3'd2,
                         S_DIV = 3'd3, S_PEAK = 3'd4, S_OUT = 3'd5;
  localparam int MW = BYTE_COUNT_BITS + 34;
  localparam logic [BYTE_COUNT_BITS-1:0] CAP = {BYTE_COUNT_BITS{1'b1}};

  logic [2:0] st_r, st_nxt;
  ipre_item_t it_r;
  logic win_open_r, answered_r;
  logic [TIME_W-1:0] last_arr_r, win_start_r, iavg_r, last_ans_r, ival_r, wlen_r;
  logic [BYTE_COUNT_BITS-1:0] bytes_r;
  logic [PEAK_W-1:0] peak_r, bps_r;
  logic [MW-1:0] prod_r;
  logic [DELTA_W-1:0] dres_r;
  logic div_start, div_done;
  logic [PEAK_W-1:0] div_q;

  function automatic logic [BYTE_COUNT_BITS-1:0] sat_add(
    input logic [BYTE_COUNT_BITS-1:0] c, input logic [LEN_W-1:0] a);
    logic [BYTE_COUNT_BITS:0] s;
    s = {1'b0, c} + (BYTE_COUNT_BITS+1)'(a);
    return s[BYTE_COUNT_BITS] ? CAP : s[BYTE_COUNT_BITS-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] ewma62(input logic [TIME_W-1:0] o,
    input logic [TIME_W-1:0] s, input logic up);
    logic [TIME_W-1:0] d;
    d = (s >= o) ? s - o : o - s;
    d = up ? d >> 1 : d >> 3;
    return (s >= o) ? o + d : o - d;
  endfunction

  function automatic logic [PEAK_W-1:0] ewma48(input logic [PEAK_W-1:0] o,
    input logic [PEAK_W-1:0] s, input logic up);
    logic [PEAK_W-1:0] d;
    d = (s >= o) ? s - o : o - s;
    d = up ? d >> 1 : d >> 3;
    return (s >= o) ? o + d : o - d;
  endfunction

  logic [TIME_W-1:0] iavg_new, elapsed;
  logic [PEAK_W+4-1:0] tgt15;
  logic [DELTA_W-1:0] qans;
  assign q_take = (st_r == S_IDLE) && q_valid;
  assign iavg_new = (iavg_r == '0) ? ival_r : ewma62(iavg_r, ival_r, ival_r > iavg_r);
  assign elapsed  = (q_item.now > last_ans_r) ? q_item.now - last_ans_r : '0;
  assign tgt15    = {peak_r, 4'b0} - {4'b0, peak_r};
  assign qans     = 49'(tgt15[PEAK_W+3:4]) - 49'(q_item.cur);
  assign div_start = (st_r == S_MUL);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_take) begin
        if (q_item.func == FUNC_QUERY) st_nxt = S_OUT;
        else if (win_open_r && q_item.now > last_arr_r) st_nxt = S_AVG;
      end
      S_AVG:  st_nxt = (ival_r > iavg_new && wlen_r != '0) ? S_MUL : S_IDLE;
      S_MUL:  st_nxt = S_DIV;
      S_DIV:  if (div_done) st_nxt = S_PEAK;
      S_PEAK: st_nxt = S_IDLE;
      S_OUT:  if (out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      win_open_r <= 1'b0; answered_r <= 1'b0;
      last_arr_r <= '0; win_start_r <= '0; bytes_r <= '0;
      iavg_r <= '0; peak_r <= '0; last_ans_r <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: if (q_take) begin
          if (q_item.func == FUNC_QUERY) begin
            if (answered_r && elapsed < 62'(holdoff)) begin
              dres_r <= '0;
            end else begin
              answered_r <= 1'b1;
              last_ans_r <= q_item.now;
              dres_r <= (peak_r == '0) ? '0 : qans;
            end
          end else if (!win_open_r) begin
            win_open_r <= 1'b1;
            last_arr_r <= q_item.now;
            win_start_r <= q_item.now;
            bytes_r <= sat_add('0, q_item.len);
          end else begin
            last_arr_r <= q_item.now;
            if (q_item.now > last_arr_r) ival_r <= q_item.now - last_arr_r;
            else bytes_r <= sat_add(bytes_r, q_item.len);
            wlen_r <= (q_item.now > win_start_r) ? q_item.now - win_start_r : '0;
          end
        end
        S_AVG: begin
          iavg_r <= iavg_new;
          if (ival_r > iavg_new) begin
            prod_r <= MW'(bytes_r) * MW'(BPS_SCALE);
            win_start_r <= it_r.now;
            if (wlen_r == '0) bytes_r <= sat_add('0, it_r.len);
          end else begin
            bytes_r <= sat_add(bytes_r, it_r.len);
          end
        end
        S_MUL: bytes_r <= sat_add('0, it_r.len);
        S_DIV: if (div_done) bps_r <= div_q;
        S_PEAK: peak_r <= (peak_r == '0) ? bps_r : ewma48(peak_r, bps_r, bps_r > peak_r);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) it_r <= q_item;
  end

  ipre_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(128'(prod_r)), .divisor(wlen_r),
    .done(div_done), .quot(div_q)
  );

  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {1'b0, iavg_r, peak_r, dres_r};

`ifndef NO_ASSERTIONS
  a_idle_take: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> st_r == S_IDLE) else $error("item taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> st_r == S_DIV) else $error("divider done outside divide");
`endif
endmodule
